// ----- hw/rtl/acfp_pkg.sv -----
// types, constants and phase helpers for the challenge field parser
package acfp_pkg;

   localparam logic [7:0] HEADER_BYTES = 8'd10;

   typedef enum logic [3:0] {
      PH_HEADER    = 4'd0,
      PH_FLAG      = 4'd1,
      PH_N_LEN     = 4'd2,
      PH_N_DATA    = 4'd3,
      PH_G_LEN     = 4'd4,
      PH_G_DATA    = 4'd5,
      PH_SALT_LEN  = 4'd6,
      PH_SALT_DATA = 4'd7,
      PH_B_LEN     = 4'd8,
      PH_B_DATA    = 4'd9,
      PH_ITER      = 4'd10,
      PH_OPT_LEN   = 4'd11,
      PH_OPT_DATA  = 4'd12,
      PH_TRAIL     = 4'd13
   } phase_type;

   typedef enum logic [1:0] {
      ST_IN_PROGRESS = 2'd0,
      ST_COMPLETE    = 2'd1,
      ST_TRUNCATED   = 2'd2
   } status_type;

   localparam logic [15:0] ITER_BYTES   = 16'd8;
   localparam logic [15:0] LEN16_BYTES  = 16'd2;
   localparam logic [15:0] SINGLE_BYTE  = 16'd1;
   localparam logic [15:0] OFFSET_MAX   = 16'hFFFF;

   localparam phase_type RESET_PHASE = (HEADER_BYTES == 8'd0) ? PH_FLAG : PH_HEADER;

   function automatic logic is_data_phase(input phase_type ph);
      return (ph == PH_N_DATA) || (ph == PH_G_DATA) || (ph == PH_SALT_DATA) ||
             (ph == PH_B_DATA) || (ph == PH_OPT_DATA);
   endfunction

   function automatic logic is_len16_phase(input phase_type ph);
      return (ph == PH_N_LEN) || (ph == PH_G_LEN) || (ph == PH_B_LEN) ||
             (ph == PH_OPT_LEN);
   endfunction

endpackage

// ----- hw/rtl/auth_challenge_field_parser.sv -----
// challenge message field parser: tags each byte with its field and offset
//
//  channel | dir | tdata                         | tuser      | tlast
//  req     | in  | data_byte                     | -          | end_of_message
//  rsp     | out | value, offset, end, status,   | field_kind | last
//          |     | iteration count               |            |
//
// one byte per cycle while rsp is not stalled, one result per byte, result registered in the cycle after accept
// field state updates with each accepted byte; the byte with tlast rearms the parser
// synchronous active-high reset returns the parser to the header field
// a stalled rsp holds its register; req_tready follows rsp_tready while rsp is full
module auth_challenge_field_parser
   import acfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] byte_value, [23:8] field_offset, [24] field_end, [26:25] parse_status,
   // [90:27] iteration_count, [95:91] zero
   output logic [95:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,   // [3:0] field_kind
   output logic        rsp_tlast
);

   phase_type   phase_ff, phase_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [63:0] iter_ff, iter_in;
   logic        done_ff, done_in;

   logic        rsp_valid_ff;
   phase_type   kind_ff, kind_in;
   logic [7:0]  value_ff;
   logic [15:0] field_offset_ff;
   logic        field_end_ff, field_end_in;
   status_type  status_ff, status_in;
   logic [63:0] count_ff, count_in;
   logic        last_ff;

   logic        accept;
   logic        trailing;
   logic [15:0] bytes_dec;
   logic        field_done;
   logic [7:0]  len_high;
   logic [15:0] blob_len;
   phase_type   step_phase;
   phase_type   enter_phase;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // codes 14 and 15 cannot occur but act as trailing
   assign trailing   = (phase_ff >= PH_TRAIL);
   assign bytes_dec  = bytes_left_ff - {15'd0, (bytes_left_ff != 16'd0)};
   assign field_done = !trailing && (bytes_dec == 16'd0);
   assign len_high   = (is_len16_phase(phase_ff) && bytes_left_ff == LEN16_BYTES) ?
                       req_tdata : length_high_ff;

   always_comb begin
      if (phase_ff == PH_SALT_LEN) begin
         blob_len = {8'd0, req_tdata};
      end else if (is_len16_phase(phase_ff)) begin
         blob_len = {len_high, req_tdata};
      end else begin
         blob_len = 16'd0;
      end
      step_phase = phase_type'(phase_ff + 4'd1);
      // empty blobs go straight to the following field
      if (is_data_phase(step_phase) && blob_len == 16'd0) begin
         enter_phase = phase_type'(step_phase + 4'd1);
      end else begin
         enter_phase = step_phase;
      end
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      offset_in      = offset_ff;
      length_high_in = length_high_ff;
      iter_in        = iter_ff;
      done_in        = done_ff;
      if (trailing) begin
         if (offset_ff != OFFSET_MAX) begin
            offset_in = offset_ff + 16'd1;
         end
      end else begin
         length_high_in = len_high;
         if (phase_ff == PH_ITER) begin
            iter_in = {iter_ff[55:0], req_tdata};
         end
         bytes_left_in = bytes_dec;
         offset_in     = offset_ff + 16'd1;
         if (field_done) begin
            phase_in  = enter_phase;
            offset_in = 16'd0;
            if (enter_phase == PH_FLAG || enter_phase == PH_SALT_LEN) begin
               bytes_left_in = SINGLE_BYTE;
            end else if (is_len16_phase(enter_phase)) begin
               bytes_left_in = LEN16_BYTES;
            end else if (is_data_phase(enter_phase)) begin
               bytes_left_in = blob_len;
            end else if (enter_phase == PH_ITER) begin
               bytes_left_in = ITER_BYTES;
            end else begin
               bytes_left_in = 16'd0;
               done_in       = 1'b1;
            end
         end
      end
   end

   // result fields
   always_comb begin
      kind_in      = trailing ? PH_TRAIL : phase_ff;
      field_end_in = field_done;
      status_in    = ST_IN_PROGRESS;
      count_in     = 64'd0;
      if (req_tlast) begin
         status_in = done_in ? ST_COMPLETE : ST_TRUNCATED;
         if (done_in) begin
            count_in = iter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= RESET_PHASE;
         bytes_left_ff  <= {8'd0, HEADER_BYTES};
         offset_ff      <= 16'd0;
         length_high_ff <= 8'd0;
         iter_ff        <= 64'd0;
         done_ff        <= 1'b0;
      end else if (accept) begin
         if (req_tlast) begin
            // rearm for the next message
            phase_ff       <= RESET_PHASE;
            bytes_left_ff  <= {8'd0, HEADER_BYTES};
            offset_ff      <= 16'd0;
            length_high_ff <= 8'd0;
            iter_ff        <= 64'd0;
            done_ff        <= 1'b0;
         end else begin
            phase_ff       <= phase_in;
            bytes_left_ff  <= bytes_left_in;
            offset_ff      <= offset_in;
            length_high_ff <= length_high_in;
            iter_ff        <= iter_in;
            done_ff        <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff         <= kind_in;
         value_ff        <= req_tdata;
         field_offset_ff <= offset_ff;
         field_end_ff    <= field_end_in;
         status_ff       <= status_in;
         count_ff        <= count_in;
         last_ff         <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, count_ff, status_ff, field_end_ff, field_offset_ff, value_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule
